// File: src/spims_pkg.sv
package spims_pkg;

  // Frame length used when the top level is not overridden.
  localparam int DEF_DATA_BITS = 8;

  // Widths fixed by the item fields.
  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 2;
  localparam int RATE_W  = 3;
  localparam int DIV_W   = 7;
  localparam int ADDR_W  = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  // Request codes carried by an input item. Code 3 is treated as a plain tick.
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Configuration register indexes (byte address is 4 times the index).
  localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POLARITY = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LSB      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RATE     = 3'd4;

  // Highest prescaler code; larger codes act as this one.
  localparam logic [RATE_W-1:0] RATE_MAX   = 3'd6;
  localparam logic [RATE_W-1:0] RATE_RESET = 3'd1;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] write_data;
    logic              miso_in;
  } spims_in_t;

  typedef struct packed {
    logic              sck_out;
    logic              mosi_out;
    logic              busy_res;
    logic              done_flag;
    logic              collision_flag;
    logic [BYTE_W-1:0] read_data;
  } spims_out_t;

endpackage

// File: src/spi_master_shift_engine_core.sv
// SPI master shift engine with programmable clock polarity, clock phase, bit
// order and a prescaler whose rate code 0 to 6 sets the SCK period. Every input
// item is one system clock tick and may carry a data write (starts a frame
// when idle, raises the collision flag when busy) or a data read (returns the
// receive buffer and clears the done and collision flags). Each item yields
// exactly one result item holding the line levels and flags after that tick.
// An item is accepted while the result register is empty or being taken, so
// a stalled consumer holds off the input only while that register is full.
// The tick update is one combinational pass from the state registers into the
// state and result registers: one item per clock while the consumer keeps up.
// The user must write configuration over the APB-style port only while no
// item is pending; the block does not enforce this.
module spi_master_shift_engine_core #(
  parameter int DATA_BITS = spims_pkg::DEF_DATA_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  spims_pkg::spims_in_t           in_data,
  // Result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output spims_pkg::spims_out_t          out_data,
  // Configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [spims_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [spims_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [spims_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                           cfg_pready
);
  import spims_pkg::*;

  localparam int FRAME_EDGES = 2 * DATA_BITS;
  localparam int EDGE_W      = $clog2(FRAME_EDGES + 1);

  // Configuration registers.
  logic              enable_r;
  logic              polarity_r;
  logic              phase_r;
  logic              lsb_first_r;
  logic [RATE_W-1:0] rate_r;

  // Engine state.
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [DATA_BITS-1:0] rx_buf_r, rx_buf_nxt;
  logic [EDGE_W-1:0]    edge_cnt_r, edge_cnt_nxt;
  logic [DIV_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic                 sck_r, sck_nxt;
  logic                 active_r, active_nxt;
  logic                 complete_r, complete_nxt;
  logic                 collided_r, collided_nxt;
  logic                 sampled_r, sampled_nxt;

  // Result register.
  logic       out_valid_r;
  spims_out_t out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;

  // One place of the shift register, taking the captured bit in at the far end.
  function automatic logic [DATA_BITS-1:0] shift_once(input logic [DATA_BITS-1:0] s,
                                                     input logic lsb, input logic b);
    logic [DATA_BITS-1:0] r;
    if (lsb) begin
      r = {b, s[DATA_BITS-1:1]};
    end else begin
      r = {s[DATA_BITS-2:0], b};
    end
    return r;
  endfunction

  // Handshake: the result register parts the two sides.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration access.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_ENABLE:   cfg_prdata = PDATA_W'(enable_r);
      REG_POLARITY: cfg_prdata = PDATA_W'(polarity_r);
      REG_PHASE:    cfg_prdata = PDATA_W'(phase_r);
      REG_LSB:      cfg_prdata = PDATA_W'(lsb_first_r);
      REG_RATE:     cfg_prdata = PDATA_W'(rate_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      polarity_r  <= 1'b0;
      phase_r     <= 1'b0;
      lsb_first_r <= 1'b0;
      rate_r      <= RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_ENABLE:   enable_r    <= cfg_pwdata[0];
        REG_POLARITY: polarity_r  <= cfg_pwdata[0];
        REG_PHASE:    phase_r     <= cfg_pwdata[0];
        REG_LSB:      lsb_first_r <= cfg_pwdata[0];
        REG_RATE:     rate_r      <= cfg_pwdata[RATE_W-1:0];
        default:      ;
      endcase
    end
  end

  // One tick of the engine: request first, then the prescaler and shifter.
  always_comb begin
    logic              started;
    logic [RATE_W-1:0] rate_eff;
    logic [DIV_W-1:0]  half;
    logic [DIV_W-1:0]  div_inc;
    logic [EDGE_W-1:0] k;
    logic              leading;
    logic [BYTE_W-1:0] rdata;

    shift_nxt    = shift_r;
    rx_buf_nxt   = rx_buf_r;
    edge_cnt_nxt = edge_cnt_r;
    div_cnt_nxt  = div_cnt_r;
    sck_nxt      = sck_r;
    active_nxt   = active_r;
    complete_nxt = complete_r;
    collided_nxt = collided_r;
    sampled_nxt  = sampled_r;
    started      = 1'b0;
    rdata        = '0;
    k            = '0;
    leading      = 1'b0;

    rate_eff = (rate_r > RATE_MAX) ? RATE_MAX : rate_r;
    half     = DIV_W'(1) << rate_eff;
    div_inc  = div_cnt_r + DIV_W'(1);

    // Data register access.
    if (in_data.req_type == REQ_WRITE) begin
      if (active_r) begin
        collided_nxt = 1'b1;
      end else begin
        shift_nxt = DATA_BITS'(in_data.write_data);
        if (enable_r) begin
          edge_cnt_nxt = '0;
          div_cnt_nxt  = '0;
          sck_nxt      = polarity_r;
          active_nxt   = 1'b1;
          started      = 1'b1;
        end
      end
    end else if (in_data.req_type == REQ_READ) begin
      rdata        = BYTE_W'(rx_buf_r);
      complete_nxt = 1'b0;
      collided_nxt = 1'b0;
    end

    // Engine advance.
    if (!enable_r) begin
      active_nxt   = 1'b0;
      edge_cnt_nxt = '0;
      div_cnt_nxt  = '0;
      sck_nxt      = polarity_r;
    end else if (active_r && !started) begin
      if (div_inc < half) begin
        div_cnt_nxt = div_inc;
      end else begin
        div_cnt_nxt  = '0;
        k            = edge_cnt_r + EDGE_W'(1);
        edge_cnt_nxt = k;
        sck_nxt      = !sck_r;
        leading      = k[0];
        // Sampling edge captures MISO; the other edge shifts.
        if (leading == !phase_r) begin
          sampled_nxt = in_data.miso_in;
        end else if (!phase_r || k >= EDGE_W'(3)) begin
          shift_nxt = shift_once(shift_nxt, lsb_first_r, sampled_nxt);
        end
        // Frame end: latch the received word and return to idle.
        if (k >= EDGE_W'(FRAME_EDGES)) begin
          if (phase_r) begin
            shift_nxt = shift_once(shift_nxt, lsb_first_r, sampled_nxt);
          end
          rx_buf_nxt   = shift_nxt;
          complete_nxt = 1'b1;
          active_nxt   = 1'b0;
          edge_cnt_nxt = '0;
          div_cnt_nxt  = '0;
          sck_nxt      = polarity_r;
        end
      end
    end else if (!active_r) begin
      sck_nxt = polarity_r;
    end

    // Result fields show the state after the tick.
    out_data_nxt.sck_out        = sck_nxt;
    out_data_nxt.mosi_out       = active_nxt &&
                                  (lsb_first_r ? shift_nxt[0] : shift_nxt[DATA_BITS-1]);
    out_data_nxt.busy_res       = active_nxt;
    out_data_nxt.done_flag      = complete_nxt;
    out_data_nxt.collision_flag = collided_nxt;
    out_data_nxt.read_data      = rdata;
  end

  // State update on every accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= '0;
      rx_buf_r   <= '0;
      edge_cnt_r <= '0;
      div_cnt_r  <= '0;
      sck_r      <= 1'b0;
      active_r   <= 1'b0;
      complete_r <= 1'b0;
      collided_r <= 1'b0;
      sampled_r  <= 1'b0;
    end else if (in_accept) begin
      shift_r    <= shift_nxt;
      rx_buf_r   <= rx_buf_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      div_cnt_r  <= div_cnt_nxt;
      sck_r      <= sck_nxt;
      active_r   <= active_nxt;
      complete_r <= complete_nxt;
      collided_r <= collided_nxt;
      sampled_r  <= sampled_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // An idle engine keeps its counters cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (edge_cnt_r == '0) && (div_cnt_r == '0))
    else $error("idle engine with nonzero counters");

  // A running frame never reaches the final edge count.
  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (edge_cnt_r < EDGE_W'(FRAME_EDGES)))
    else $error("edge count past frame end");

  // An item processed while disabled leaves the engine idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !enable_r) |=> !active_r)
    else $error("engine running while disabled");

  // The reported busy flag matches the engine state after the item.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (out_data_r.busy_res == active_r))
    else $error("busy flag disagrees with engine state");

endmodule
